// ===== hdl/rwpp_pkg.sv =====
// Shared types and constants for the RIFF/WAVE PCM parser.
// No dependencies; every other file of the block uses it by scoped names.
`default_nettype none

package rwpp_pkg;

  // Result kinds as they leave on the result channel.
  typedef enum logic [1:0] {
    KIND_SAMPLE = 2'd0,
    KIND_HEADER = 2'd1,
    KIND_ERROR  = 2'd2,
    KIND_END    = 2'd3
  } kind_t;

  // Chunk tags, first byte in the top byte.
  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
  localparam logic [31:0] TAG_DATA = 32'h6461_7461;

  // Smallest fmt body that carries all fields we need.
  localparam logic [31:0] FMT_MIN_LEN = 32'd16;

  // Recentering flip for 8-bit (offset binary) samples.
  localparam logic [15:0] OFFSET_FLIP = 16'h8000;

  // ceil(2^33 / 3): (n * DIV3_RECIP) >> 33 equals n / 3 for every 32-bit n.
  localparam logic [31:0] DIV3_RECIP = 32'hAAAA_AAAB;

  // Depth of the queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Bytes per sample, coded as bytes minus one.
  typedef enum logic [1:0] {
    BPS_ONE   = 2'd0,
    BPS_TWO   = 2'd1,
    BPS_THREE = 2'd2,
    BPS_FOUR  = 2'd3
  } bps_code_t;

  // One command from the front to the back.
  typedef struct packed {
    kind_t        kind;
    logic [15:0]  sample;
    logic [15:0]  channels;
    logic [31:0]  rate;
    logic [31:0]  data_len;
    bps_code_t    bps;
  } cmd_t;

endpackage

`default_nettype wire

// ===== hdl/rwpp_front.sv =====
// Front end of the parser: walks the RIFF structure one byte per word and
// issues a command for every result. Depends on rwpp_pkg.
`default_nettype none

module rwpp_front #(
  parameter int unsigned MAX_SAMPLE_BYTES = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_fire,
  input  wire logic [7:0]    in_data_byte,
  input  wire logic          in_file_start,
  output logic               push,
  output rwpp_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    PH_RIFF_TAG   = 4'd0,
    PH_RIFF_SIZE  = 4'd1,
    PH_WAVE_TAG   = 4'd2,
    PH_CHUNK_ID   = 4'd3,
    PH_CHUNK_SIZE = 4'd4,
    PH_FMT_BODY   = 4'd5,
    PH_SKIP_BODY  = 4'd6,
    PH_PAD        = 4'd7,
    PH_DATA       = 4'd8,
    PH_AFTER_DATA = 4'd9,
    PH_IDLE       = 4'd10
  } phase_t;

  phase_t      phase_r, phase_nxt, phase_c;
  logic [31:0] idx_r, idx_nxt, idx_c, idx_inc;
  logic [31:0] tag_r, tag_nxt, tag_c, tag_new;
  logic [31:0] len_r, len_nxt, len_c, len_new;
  logic [15:0] chan_r, chan_nxt, chan_c;
  logic [31:0] rate_r, rate_nxt, rate_c;
  logic [15:0] bits_r, bits_nxt, bits_c;
  logic [31:0] asm_r, asm_nxt, asm_c, asm_new;
  logic [31:0] left_r, left_nxt, left_c;
  logic [12:0] bps;
  logic        emit;
  rwpp_pkg::cmd_t cmd_c;

  always_comb begin
    // A file start restarts the walk before this byte is taken.
    phase_c = in_file_start ? PH_RIFF_TAG : phase_r;
    idx_c   = in_file_start ? 32'd0 : idx_r;
    tag_c   = in_file_start ? 32'd0 : tag_r;
    len_c   = in_file_start ? 32'd0 : len_r;
    chan_c  = in_file_start ? 16'd0 : chan_r;
    rate_c  = in_file_start ? 32'd0 : rate_r;
    bits_c  = in_file_start ? 16'd0 : bits_r;
    asm_c   = in_file_start ? 32'd0 : asm_r;
    left_c  = in_file_start ? 32'd0 : left_r;

    idx_inc = idx_c + 32'd1;
    tag_new = {tag_c[23:0], in_data_byte};
    len_new = {in_data_byte, len_c[31:8]};
    asm_new = {in_data_byte, asm_c[31:8]};
    bps     = bits_c[15:3];

    phase_nxt = phase_c;
    idx_nxt   = idx_c;
    tag_nxt   = tag_c;
    len_nxt   = len_c;
    chan_nxt  = chan_c;
    rate_nxt  = rate_c;
    bits_nxt  = bits_c;
    asm_nxt   = asm_c;
    left_nxt  = left_c;
    emit      = 1'b0;
    cmd_c     = '0;

    case (phase_c)
      PH_RIFF_TAG, PH_WAVE_TAG, PH_CHUNK_ID: begin
        tag_nxt = tag_new;
        idx_nxt = idx_inc;
        if (idx_inc == 32'd4) begin
          idx_nxt = 32'd0;
          if (phase_c == PH_RIFF_TAG) begin
            if (tag_new != rwpp_pkg::TAG_RIFF) begin
              phase_nxt  = PH_IDLE;
              emit       = 1'b1;
              cmd_c.kind = rwpp_pkg::KIND_ERROR;
            end else begin
              phase_nxt = PH_RIFF_SIZE;
            end
          end else if (phase_c == PH_WAVE_TAG) begin
            if (tag_new != rwpp_pkg::TAG_WAVE) begin
              phase_nxt  = PH_IDLE;
              emit       = 1'b1;
              cmd_c.kind = rwpp_pkg::KIND_ERROR;
            end else begin
              phase_nxt = PH_CHUNK_ID;
            end
          end else begin
            phase_nxt = PH_CHUNK_SIZE;
          end
        end
      end
      PH_RIFF_SIZE, PH_CHUNK_SIZE: begin
        len_nxt = len_new;
        idx_nxt = idx_inc;
        if (idx_inc == 32'd4) begin
          idx_nxt = 32'd0;
          if (phase_c == PH_RIFF_SIZE) begin
            phase_nxt = PH_WAVE_TAG;
          end else if (tag_c == rwpp_pkg::TAG_FMT) begin
            if (len_new < rwpp_pkg::FMT_MIN_LEN) begin
              phase_nxt  = PH_IDLE;
              emit       = 1'b1;
              cmd_c.kind = rwpp_pkg::KIND_ERROR;
            end else begin
              phase_nxt = PH_FMT_BODY;
            end
          end else if (tag_c == rwpp_pkg::TAG_DATA) begin
            emit = 1'b1;
            if (bps == 13'd0 || bps > 13'(MAX_SAMPLE_BYTES)) begin
              phase_nxt  = PH_IDLE;
              cmd_c.kind = rwpp_pkg::KIND_ERROR;
            end else begin
              left_nxt       = len_new;
              asm_nxt        = 32'd0;
              phase_nxt      = (len_new == 32'd0) ? PH_AFTER_DATA : PH_DATA;
              cmd_c.kind     = rwpp_pkg::KIND_HEADER;
              cmd_c.channels = chan_c;
              cmd_c.rate     = rate_c;
              cmd_c.data_len = len_new;
              cmd_c.bps      = rwpp_pkg::bps_code_t'(bps[1:0] - 2'd1);
            end
          end else begin
            phase_nxt = (len_new == 32'd0) ? PH_CHUNK_ID : PH_SKIP_BODY;
          end
        end
      end
      PH_FMT_BODY, PH_SKIP_BODY: begin
        if (phase_c == PH_FMT_BODY) begin
          if (idx_c == 32'd2)  chan_nxt[7:0]   = in_data_byte;
          if (idx_c == 32'd3)  chan_nxt[15:8]  = in_data_byte;
          if (idx_c == 32'd4)  rate_nxt[7:0]   = in_data_byte;
          if (idx_c == 32'd5)  rate_nxt[15:8]  = in_data_byte;
          if (idx_c == 32'd6)  rate_nxt[23:16] = in_data_byte;
          if (idx_c == 32'd7)  rate_nxt[31:24] = in_data_byte;
          if (idx_c == 32'd14) bits_nxt[7:0]   = in_data_byte;
          if (idx_c == 32'd15) bits_nxt[15:8]  = in_data_byte;
        end
        idx_nxt = idx_inc;
        if (idx_inc == len_c) begin
          // An odd-sized body is followed by one pad byte.
          idx_nxt   = 32'd0;
          phase_nxt = len_c[0] ? PH_PAD : PH_CHUNK_ID;
        end
      end
      PH_PAD: begin
        idx_nxt   = 32'd0;
        phase_nxt = PH_CHUNK_ID;
      end
      PH_DATA: begin
        asm_nxt  = asm_new;
        idx_nxt  = idx_inc;
        left_nxt = left_c - 32'd1;
        if (left_nxt == 32'd0) begin
          phase_nxt = PH_AFTER_DATA;
        end
        if (idx_inc >= 32'(bps)) begin
          idx_nxt      = 32'd0;
          asm_nxt      = 32'd0;
          emit         = 1'b1;
          cmd_c.kind   = rwpp_pkg::KIND_SAMPLE;
          cmd_c.sample = asm_new[31:16] ^
                         ((bps == 13'd1) ? rwpp_pkg::OFFSET_FLIP : 16'd0);
        end
      end
      PH_AFTER_DATA: begin
        phase_nxt  = PH_IDLE;
        emit       = 1'b1;
        cmd_c.kind = rwpp_pkg::KIND_END;
      end
      default: begin
        phase_nxt = phase_c;
      end
    endcase
  end

  assign push = in_fire && emit;
  assign cmd  = cmd_c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RIFF_TAG;
      idx_r   <= 32'd0;
      tag_r   <= 32'd0;
      len_r   <= 32'd0;
      chan_r  <= 16'd0;
      rate_r  <= 32'd0;
      bits_r  <= 16'd0;
      asm_r   <= 32'd0;
      left_r  <= 32'd0;
    end else if (in_fire) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      tag_r   <= tag_nxt;
      len_r   <= len_nxt;
      chan_r  <= chan_nxt;
      rate_r  <= rate_nxt;
      bits_r  <= bits_nxt;
      asm_r   <= asm_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/rwpp_queue.sv =====
// Short command queue between the parser front and the result back end.
// Depends on rwpp_pkg for the command type and the depth.
`default_nettype none

module rwpp_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire rwpp_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output rwpp_pkg::cmd_t      head,
  output logic                empty,
  output logic                full
);

  localparam int unsigned DEPTH = rwpp_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  rwpp_pkg::cmd_t    entries_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  assign empty = (count_r == CNT_W'(0));
  assign full  = (count_r == CNT_W'(DEPTH));
  assign head  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

  a_no_underrun: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue popped while empty");

  a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("queue push lost");

endmodule

`default_nettype wire

// ===== hdl/rwpp_back.sv =====
// Back end: takes commands from the queue, finishes the sample count and
// holds the result word for the output channel. Depends on rwpp_pkg.
`default_nettype none

module rwpp_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rwpp_pkg::cmd_t head,
  input  wire logic           empty,
  output logic                pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [1:0]          out_result_kind,
  output logic signed [15:0]  out_sample_value,
  output logic [15:0]         out_channel_count,
  output logic [31:0]         out_rate_hz,
  output logic [31:0]         out_total_samples
);

  // Stage A: command plus the quotient of the divide by three.
  logic           a_valid_r, a_valid_nxt;
  rwpp_pkg::cmd_t a_cmd_r;
  logic [31:0]    a_div3_r;

  // Stage B: the result word on the ports.
  logic           b_valid_r, b_valid_nxt;
  rwpp_pkg::kind_t b_kind_r;
  logic [15:0]    b_sample_r;
  logic [15:0]    b_chan_r;
  logic [31:0]    b_rate_r;
  logic [31:0]    b_total_r;
  logic [31:0]    total_c;

  logic b_free, a_adv, a_free;

  assign b_free = !b_valid_r || out_ready;
  assign a_adv  = a_valid_r && b_free;
  assign a_free = !a_valid_r || a_adv;
  assign pop    = !empty && a_free;

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (pop) begin
      a_valid_nxt = 1'b1;
    end else if (a_adv) begin
      a_valid_nxt = 1'b0;
    end
    b_valid_nxt = b_valid_r;
    if (a_adv) begin
      b_valid_nxt = 1'b1;
    end else if (out_ready) begin
      b_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    case (a_cmd_r.bps)
      rwpp_pkg::BPS_ONE:   total_c = a_cmd_r.data_len;
      rwpp_pkg::BPS_TWO:   total_c = {1'b0, a_cmd_r.data_len[31:1]};
      rwpp_pkg::BPS_THREE: total_c = a_div3_r;
      rwpp_pkg::BPS_FOUR:  total_c = {2'b00, a_cmd_r.data_len[31:2]};
      default:             total_c = a_cmd_r.data_len;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      a_cmd_r  <= head;
      // The product of two 32-bit values, shifted down by 33, is below 2^31.
      a_div3_r <= 32'((64'(head.data_len) * 64'(rwpp_pkg::DIV3_RECIP)) >> 33);
    end
    if (a_adv) begin
      b_kind_r   <= a_cmd_r.kind;
      b_sample_r <= a_cmd_r.sample;
      b_chan_r   <= a_cmd_r.channels;
      b_rate_r   <= a_cmd_r.rate;
      b_total_r  <= (a_cmd_r.kind == rwpp_pkg::KIND_HEADER) ? total_c : 32'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
    end
  end

  assign out_valid         = b_valid_r;
  assign out_result_kind   = b_kind_r;
  assign out_sample_value  = $signed(b_sample_r);
  assign out_channel_count = b_chan_r;
  assign out_rate_hz       = b_rate_r;
  assign out_total_samples = b_total_r;

endmodule

`default_nettype wire

// ===== hdl/riff_wave_pcm_parser.sv =====
// Top level of the RIFF/WAVE PCM parser: front end, command queue, back end.
// Depends on rwpp_pkg, rwpp_front, rwpp_queue and rwpp_back.
//
//   Channel | Ports                                   | Direction | Word
//   --------+-----------------------------------------+-----------+---------------------
//   in_     | valid, ready, data_byte, file_start      | into      | one file byte
//   out_    | valid, ready, result_kind, sample_value, | out of    | one result (sample,
//           | channel_count, rate_hz, total_samples    |           | header, error, end)
//
// One input word is taken every cycle while the four-entry command queue has
// room; the parser front walks the file structure one byte per input word.
// A result reaches the output through the queue, the stage that forms the
// divide-by-three product and the output register, in that order.
// rst_n is synchronous and active low; it returns the parser to the start of
// a file and empties the queue and both back-end stages.
// A stall on the output fills the queue; in_ready drops only once it is full.
`default_nettype none

module riff_wave_pcm_parser #(
  parameter int unsigned MAX_SAMPLE_BYTES = 4
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic [7:0]   in_data_byte,
  input  wire logic         in_file_start,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [1:0]        out_result_kind,
  output logic signed [15:0] out_sample_value,
  output logic [15:0]       out_channel_count,
  output logic [31:0]       out_rate_hz,
  output logic [31:0]       out_total_samples
);

  logic           in_fire;
  logic           push;
  logic           pop;
  logic           q_empty;
  logic           q_full;
  rwpp_pkg::cmd_t push_cmd;
  rwpp_pkg::cmd_t q_head;

  // Every byte may cause a result, so a byte is taken only with a free slot.
  assign in_ready = !q_full;
  assign in_fire  = in_valid && in_ready;

  // The front keeps the whole parse state and turns each byte into at most
  // one command: a decoded sample, the header, an error or the end mark.
  rwpp_front #(
    .MAX_SAMPLE_BYTES (MAX_SAMPLE_BYTES)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_fire       (in_fire),
    .in_data_byte  (in_data_byte),
    .in_file_start (in_file_start),
    .push          (push),
    .cmd           (push_cmd)
  );

  // The queue lets the front keep taking bytes while a result is stalled.
  rwpp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (q_head),
    .empty    (q_empty),
    .full     (q_full)
  );

  // The back end finishes the sample count (size over bytes per sample,
  // with a reciprocal multiply for three-byte samples) and drives the port.
  rwpp_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (q_head),
    .empty             (q_empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result_kind   (out_result_kind),
    .out_sample_value  (out_sample_value),
    .out_channel_count (out_channel_count),
    .out_rate_hz       (out_rate_hz),
    .out_total_samples (out_total_samples)
  );

endmodule

`default_nettype wire
